FILE: src/mutex_deadlock_detector_unit_assert.svh
// Assertion macros shared by the deadlock detector modules.
`ifndef MUTEX_DEADLOCK_DETECTOR_UNIT_ASSERT_SVH
`define MUTEX_DEADLOCK_DETECTOR_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MDD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MDD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/mdd_pkg.sv
// Shared constants, types and helpers for the mutex deadlock detector.
package mdd_pkg;

   localparam int THREADS      = 16;
   localparam int MUTEXES      = 64;
   localparam int TW           = $clog2(THREADS);
   localparam int CW           = $clog2(THREADS + 1);
   localparam int MW           = $clog2(MUTEXES);
   localparam int CFG_W        = 5;
   localparam int RESET_ACTIVE = 16;
   localparam int STEP_LIMIT   = 4 * THREADS;
   localparam int SW           = $clog2(STEP_LIMIT + 1);
   localparam int OP_W         = 2;
   localparam int REQ_DATA_W   = ((TW + MW + 7) / 8) * 8;
   localparam int RSP_DATA_W   = ((1 + TW + 7) / 8) * 8;

   typedef enum logic [OP_W-1:0] {
      OP_NEED = 2'd0,
      OP_HAVE = 2'd1,
      OP_FREE = 2'd2
   } opcode_type;

   typedef struct packed {
      opcode_type      opcode;
      logic [TW-1:0]   thread;
      logic [MW-1:0]   mutex;
   } event_type;

   // one lookup of the wait-for graph: does the vertex have an edge, and to whom
   typedef struct packed {
      logic            valid;
      logic [TW-1:0]   target;
   } follow_rsp_type;

   function automatic logic [CW-1:0] clamp_active(input logic [CFG_W-1:0] value);
      logic [CW-1:0] result;
      if (value == '0) begin
         result = CW'(1);
      end else if (32'(value) > 32'(THREADS)) begin
         result = CW'(THREADS);
      end else begin
         result = CW'(value);
      end
      return result;
   endfunction

endpackage

FILE: src/mdd_ram.sv
// Generic simple dual-port RAM with registered read.
module mdd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/mdd_graph.sv
// Wait-for graph state: per-thread wanted mutex and wait edge, per-mutex holder.
module mdd_graph (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [mdd_pkg::MW-1:0]        hold_rd_addr,
   input  logic                          upd_en,
   input  mdd_pkg::event_type            upd_event,
   input  logic [mdd_pkg::CW-1:0]        active_count,
   input  logic [mdd_pkg::TW-1:0]        follow_vertex,
   output mdd_pkg::follow_rsp_type       follow_rsp
);

   logic [mdd_pkg::THREADS-1:0] wanted_valid_ff, wanted_valid_in;
   logic [mdd_pkg::MW-1:0]      wanted_idx_ff [mdd_pkg::THREADS];
   logic [mdd_pkg::MW-1:0]      wanted_idx_in [mdd_pkg::THREADS];
   logic [mdd_pkg::THREADS-1:0] wait_valid_ff, wait_valid_in;
   logic [mdd_pkg::TW-1:0]      wait_tgt_ff [mdd_pkg::THREADS];
   logic [mdd_pkg::TW-1:0]      wait_tgt_in [mdd_pkg::THREADS];
   logic [mdd_pkg::MUTEXES-1:0] hold_valid_ff, hold_valid_in;
   logic [mdd_pkg::TW-1:0]      hold_idx;
   logic                        hold_wr_en;

   // holder thread ids live in RAM; the valid flops say which entries mean anything
   assign hold_wr_en = upd_en && (upd_event.opcode == mdd_pkg::OP_HAVE);

   mdd_ram #(
      .WIDTH (mdd_pkg::TW),
      .DEPTH (mdd_pkg::MUTEXES)
   ) u_hold_ram (
      .clock   (clock),
      .wr_en   (hold_wr_en),
      .wr_addr (upd_event.mutex),
      .wr_data (upd_event.thread),
      .rd_addr (hold_rd_addr),
      .rd_data (hold_idx)
   );

   always_comb begin
      wanted_valid_in = wanted_valid_ff;
      wanted_idx_in   = wanted_idx_ff;
      wait_valid_in   = wait_valid_ff;
      wait_tgt_in     = wait_tgt_ff;
      hold_valid_in   = hold_valid_ff;
      if (upd_en) begin
         case (upd_event.opcode)
            mdd_pkg::OP_NEED: begin
               wanted_valid_in[upd_event.thread] = 1'b1;
               wanted_idx_in[upd_event.thread]   = upd_event.mutex;
               wait_valid_in[upd_event.thread]   = hold_valid_ff[upd_event.mutex];
               wait_tgt_in[upd_event.thread]     = hold_idx;
            end
            mdd_pkg::OP_HAVE: begin
               hold_valid_in[upd_event.mutex] = 1'b1;
               for (int i = 0; i < mdd_pkg::THREADS; i++) begin
                  if (mdd_pkg::TW'(i) == upd_event.thread) begin
                     wanted_valid_in[i] = 1'b0;
                     wait_valid_in[i]   = 1'b0;
                  end else if ((mdd_pkg::CW'(i) < active_count) && wanted_valid_ff[i] &&
                               (wanted_idx_ff[i] == upd_event.mutex)) begin
                     wait_valid_in[i] = 1'b1;
                     wait_tgt_in[i]   = upd_event.thread;
                  end
               end
            end
            mdd_pkg::OP_FREE: begin
               hold_valid_in[upd_event.mutex] = 1'b0;
               for (int i = 0; i < mdd_pkg::THREADS; i++) begin
                  if ((mdd_pkg::CW'(i) < active_count) && wanted_valid_ff[i] &&
                      (wanted_idx_ff[i] == upd_event.mutex)) begin
                     wait_valid_in[i] = 1'b0;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wanted_valid_ff <= '0;
         wait_valid_ff   <= '0;
         hold_valid_ff   <= '0;
      end else begin
         wanted_valid_ff <= wanted_valid_in;
         wait_valid_ff   <= wait_valid_in;
         hold_valid_ff   <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      wanted_idx_ff <= wanted_idx_in;
      wait_tgt_ff   <= wait_tgt_in;
   end

   // the single edge-lookup port shared by every step of the walk
   assign follow_rsp.valid  = wait_valid_ff[follow_vertex];
   assign follow_rsp.target = wait_tgt_ff[follow_vertex];

endmodule

FILE: src/mdd_walker.sv
// Cycle search sequencer: tortoise-and-hare walks and cycle listing over one edge port.
`include "mutex_deadlock_detector_unit_assert.svh"

module mdd_walker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [mdd_pkg::CW-1:0]        active_count,
   output logic [mdd_pkg::TW-1:0]        follow_vertex,
   input  mdd_pkg::follow_rsp_type       follow_rsp,
   output logic                          busy,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic                          rsp_deadlock,
   output logic [mdd_pkg::TW-1:0]        rsp_member,
   output logic                          rsp_last
);

   typedef enum logic [5:0] {
      W_IDLE  = 6'b000001,
      W_START = 6'b000010,
      W_F1    = 6'b000100,
      W_F2    = 6'b001000,
      W_S1    = 6'b010000,
      W_EMIT  = 6'b100000
   } walk_state_type;

   walk_state_type               state_ff, state_in;
   logic [mdd_pkg::CW-1:0]       root_ff, root_in;
   logic [mdd_pkg::TW-1:0]       slow_ff, slow_in;
   logic [mdd_pkg::TW-1:0]       fast_ff, fast_in;
   logic [mdd_pkg::TW-1:0]       f1_ff, f1_in;
   logic [mdd_pkg::TW-1:0]       f2_ff, f2_in;
   logic [mdd_pkg::SW-1:0]       steps_ff, steps_in;
   logic [mdd_pkg::THREADS-1:0]  visited_ff, visited_in;
   logic [mdd_pkg::TW-1:0]       it_ff, it_in;
   logic [mdd_pkg::TW-1:0]       origin_ff, origin_in;
   logic [mdd_pkg::CW-1:0]       count_ff, count_in;
   logic                         out_valid_ff, out_valid_in;
   logic                         out_deadlock_ff, out_deadlock_in;
   logic [mdd_pkg::TW-1:0]       out_member_ff, out_member_in;
   logic                         out_last_ff, out_last_in;
   logic                         out_free;
   logic [mdd_pkg::CW-1:0]       count_next;
   logic                         emit_last;

   assign out_free   = !out_valid_ff || rsp_ready;
   assign count_next = count_ff + mdd_pkg::CW'(1);
   assign emit_last  = !(follow_rsp.valid && (follow_rsp.target != origin_ff) &&
                         (count_next < active_count));

   always_comb begin
      case (state_ff)
         W_F1:    follow_vertex = fast_ff;
         W_F2:    follow_vertex = f1_ff;
         W_S1:    follow_vertex = slow_ff;
         W_EMIT:  follow_vertex = it_ff;
         default: follow_vertex = fast_ff;
      endcase
   end

   always_comb begin
      state_in        = state_ff;
      root_in         = root_ff;
      slow_in         = slow_ff;
      fast_in         = fast_ff;
      f1_in           = f1_ff;
      f2_in           = f2_ff;
      steps_in        = steps_ff;
      visited_in      = visited_ff;
      it_in           = it_ff;
      origin_in       = origin_ff;
      count_in        = count_ff;
      out_valid_in    = out_valid_ff && !rsp_ready;
      out_deadlock_in = out_deadlock_ff;
      out_member_in   = out_member_ff;
      out_last_in     = out_last_ff;
      case (state_ff)
         W_IDLE: begin
            if (start) begin
               visited_in = '0;
               root_in    = '0;
               state_in   = W_START;
            end
         end
         W_START: begin
            if (root_ff >= active_count) begin
               // no walk met itself: one clean transaction
               if (out_free) begin
                  out_valid_in    = 1'b1;
                  out_deadlock_in = 1'b0;
                  out_member_in   = '0;
                  out_last_in     = 1'b1;
                  state_in        = W_IDLE;
               end
            end else if (visited_ff[root_ff[mdd_pkg::TW-1:0]]) begin
               root_in = root_ff + mdd_pkg::CW'(1);
            end else begin
               slow_in  = root_ff[mdd_pkg::TW-1:0];
               fast_in  = root_ff[mdd_pkg::TW-1:0];
               steps_in = '0;
               state_in = W_F1;
            end
         end
         W_F1: begin
            if ((steps_ff >= mdd_pkg::SW'(mdd_pkg::STEP_LIMIT)) || !follow_rsp.valid) begin
               root_in  = root_ff + mdd_pkg::CW'(1);
               state_in = W_START;
            end else begin
               f1_in    = follow_rsp.target;
               state_in = W_F2;
            end
         end
         W_F2: begin
            if (!follow_rsp.valid) begin
               root_in  = root_ff + mdd_pkg::CW'(1);
               state_in = W_START;
            end else begin
               f2_in               = follow_rsp.target;
               visited_in[slow_ff] = 1'b1;
               visited_in[fast_ff] = 1'b1;
               state_in            = W_S1;
            end
         end
         W_S1: begin
            if (!follow_rsp.valid) begin
               root_in  = root_ff + mdd_pkg::CW'(1);
               state_in = W_START;
            end else begin
               slow_in  = follow_rsp.target;
               fast_in  = f2_ff;
               steps_in = steps_ff + mdd_pkg::SW'(1);
               if (follow_rsp.target == f2_ff) begin
                  origin_in = follow_rsp.target;
                  it_in     = follow_rsp.target;
                  count_in  = '0;
                  state_in  = W_EMIT;
               end else begin
                  state_in = W_F1;
               end
            end
         end
         W_EMIT: begin
            if (out_free) begin
               out_valid_in    = 1'b1;
               out_deadlock_in = 1'b1;
               out_member_in   = it_ff;
               out_last_in     = emit_last;
               it_in           = follow_rsp.target;
               count_in        = count_next;
               if (emit_last) begin
                  state_in = W_IDLE;
               end
            end
         end
         default: begin
            state_in = W_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= W_IDLE;
         out_valid_ff <= 1'b0;
         root_ff      <= '0;
         steps_ff     <= '0;
         count_ff     <= '0;
         visited_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         root_ff      <= root_in;
         steps_ff     <= steps_in;
         count_ff     <= count_in;
         visited_ff   <= visited_in;
      end
   end

   always_ff @(posedge clock) begin
      slow_ff         <= slow_in;
      fast_ff         <= fast_in;
      f1_ff           <= f1_in;
      f2_ff           <= f2_in;
      it_ff           <= it_in;
      origin_ff       <= origin_in;
      out_deadlock_ff <= out_deadlock_in;
      out_member_ff   <= out_member_in;
      out_last_ff     <= out_last_in;
   end

   assign busy         = (state_ff != W_IDLE);
   assign rsp_valid    = out_valid_ff;
   assign rsp_deadlock = out_deadlock_ff;
   assign rsp_member   = out_member_ff;
   assign rsp_last     = out_last_ff;

   `MDD_ASSERT_NOW(a_walk_marks, clock, reset, state_ff == W_S1, visited_ff[slow_ff] && visited_ff[fast_ff], "walk vertices not marked before slow step")
   `MDD_ASSERT_NOW(a_step_bound, clock, reset, state_ff == W_S1, steps_ff < mdd_pkg::SW'(mdd_pkg::STEP_LIMIT), "walk ran past its step limit")
   `MDD_ASSERT_NOW(a_emit_bound, clock, reset, state_ff == W_EMIT, count_ff < mdd_pkg::CW'(mdd_pkg::THREADS), "cycle listing longer than thread count")
   `MDD_ASSERT_NOW(a_emit_origin, clock, reset, state_ff == W_EMIT && count_ff == '0, it_ff == origin_ff, "cycle listing does not begin at meeting vertex")

endmodule

FILE: src/mutex_deadlock_detector_unit.sv
// Top level of the mutex deadlock detector: event intake, config register, wiring.
//
// Tracks a wait-for graph of up to 16 threads and 64 mutexes from need, have and
// free events and, on each need event, searches it for a wait cycle. One event is
// taken at a time; req_tready is low until the event is done. A have or free event
// is accepted, then applied as a graph update. A need event is accepted, applied as
// a graph update and followed by the search, and control is handed back once the
// search is done. The search runs on a single edge-lookup port of the graph: it looks
// at start vertices in turn (marked or not), walks tortoise-and-hare from unmarked
// ones (three lookups per step, at most 4*THREADS steps per start, plus the lookup
// that ends a walk), then gives the no-deadlock result or one result per reported
// cycle member, held up while the rsp side stalls. The last result sits in the
// output register while the next event is accepted. Mutex holder ids live in a RAM
// gated by per-entry valid flops, so there is no clearing pass after reset.
`include "mutex_deadlock_detector_unit_assert.svh"

module mutex_deadlock_detector_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_enable,
   input  logic [mdd_pkg::CFG_W-1:0]         csr_write_data,   // active_threads
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [mdd_pkg::REQ_DATA_W-1:0]    req_tdata,        // thread_index, mutex_index
   input  logic [mdd_pkg::OP_W-1:0]          req_tuser,        // opcode
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [mdd_pkg::RSP_DATA_W-1:0]    rsp_tdata,        // deadlock, member_thread
   output logic                              rsp_tlast         // last
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_EXEC = 3'b010,
      ST_WALK = 3'b100
   } top_state_type;

   top_state_type                  state_ff, state_in;
   mdd_pkg::event_type             ev_ff, ev_in;
   logic [mdd_pkg::CFG_W-1:0]      active_ff, active_in;
   logic [mdd_pkg::CW-1:0]         active_count;
   logic                           accept;
   logic                           upd_en;
   logic                           walk_start;
   logic                           walk_busy;
   logic [mdd_pkg::TW-1:0]         follow_vertex;
   mdd_pkg::follow_rsp_type        follow_rsp;
   logic                           rsp_deadlock;
   logic [mdd_pkg::TW-1:0]         rsp_member;
   logic [mdd_pkg::MW-1:0]         req_mutex;

   assign req_tready   = (state_ff == ST_IDLE);
   assign accept       = req_tvalid && req_tready;
   assign active_count = mdd_pkg::clamp_active(active_ff);
   assign req_mutex    = req_tdata[mdd_pkg::TW+mdd_pkg::MW-1:mdd_pkg::TW];
   assign active_in    = csr_write_enable ? csr_write_data : active_ff;

   always_comb begin
      ev_in = ev_ff;
      if (accept) begin
         ev_in.opcode = mdd_pkg::opcode_type'(req_tuser);
         ev_in.thread = req_tdata[mdd_pkg::TW-1:0];
         ev_in.mutex  = req_mutex;
      end
   end

   always_comb begin
      state_in   = state_ff;
      upd_en     = 1'b0;
      walk_start = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            // holder RAM read issued at accept is valid here
            upd_en = 1'b1;
            if (ev_ff.opcode == mdd_pkg::OP_NEED) begin
               walk_start = 1'b1;
               state_in   = ST_WALK;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_WALK: begin
            if (!walk_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         active_ff <= mdd_pkg::CFG_W'(mdd_pkg::RESET_ACTIVE);
      end else begin
         state_ff  <= state_in;
         active_ff <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      ev_ff <= ev_in;
   end

   mdd_graph u_graph (
      .clock         (clock),
      .reset         (reset),
      .hold_rd_addr  (req_mutex),
      .upd_en        (upd_en),
      .upd_event     (ev_ff),
      .active_count  (active_count),
      .follow_vertex (follow_vertex),
      .follow_rsp    (follow_rsp)
   );

   mdd_walker u_walker (
      .clock         (clock),
      .reset         (reset),
      .start         (walk_start),
      .active_count  (active_count),
      .follow_vertex (follow_vertex),
      .follow_rsp    (follow_rsp),
      .busy          (walk_busy),
      .rsp_ready     (rsp_tready),
      .rsp_valid     (rsp_tvalid),
      .rsp_deadlock  (rsp_deadlock),
      .rsp_member    (rsp_member),
      .rsp_last      (rsp_tlast)
   );

   assign rsp_tdata = mdd_pkg::RSP_DATA_W'({rsp_member, rsp_deadlock});

   `MDD_ASSERT_NEXT(a_need_starts_walk, clock, reset, state_ff == ST_EXEC && ev_ff.opcode == mdd_pkg::OP_NEED, walk_busy, "need transaction did not start the search")
   `MDD_ASSERT_NOW(a_walk_blocks_req, clock, reset, walk_busy, !req_tready, "new transaction accepted during search")

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the mutex deadlock detector: lock events in, cycle reports out.
`timescale 1ns / 1ps

module tb_top;

   localparam int OP_W         = mdd_pkg::OP_W;
   localparam int TW           = mdd_pkg::TW;
   localparam int MW           = mdd_pkg::MW;
   localparam int CFG_W        = mdd_pkg::CFG_W;
   localparam int THREADS      = mdd_pkg::THREADS;
   localparam int MUTEXES      = mdd_pkg::MUTEXES;
   localparam int REQ_DATA_W   = mdd_pkg::REQ_DATA_W;
   localparam int RSP_DATA_W   = mdd_pkg::RSP_DATA_W;
   localparam int STEP_LIMIT   = mdd_pkg::STEP_LIMIT;

   localparam logic [OP_W-1:0] OP_UNUSED  = 2'd3;
   localparam logic [MW-1:0]   SPARE_LOCK = 6'd63;
   localparam int              HOLD_CYCLES = 400;
   localparam int              DRAIN_LIMIT = 100000;
   localparam int              SETTLE_CYCLES = 24;

   typedef struct packed {
      logic          deadlock;
      logic [TW-1:0] member;
      logic          last;
   } cycle_entry_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_write_enable = 1'b0;
   logic [CFG_W-1:0]      csr_write_data = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;   // thread_index, mutex_index
   logic [OP_W-1:0]       req_tuser = '0;   // opcode
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // deadlock, member_thread
   logic                  rsp_tlast;

   mutex_deadlock_detector_unit dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .req_tuser        (req_tuser),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .rsp_tlast        (rsp_tlast)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // shadow copy of the wait-for graph
   logic               waits_on_valid [THREADS];
   logic [MW-1:0]      waits_on       [THREADS];
   logic               owner_valid    [MUTEXES];
   logic [TW-1:0]      owner          [MUTEXES];
   logic               points_to_valid[THREADS];
   logic [TW-1:0]      points_to      [THREADS];
   logic               marked         [THREADS];
   logic [CFG_W-1:0]   active_cfg = mdd_pkg::CFG_W'(mdd_pkg::RESET_ACTIVE);

   cycle_entry_type pending_reports[$];
   int error_count = 0;
   int sent_count = 0;
   bit sender_calm = 1'b0;
   bit receiver_calm = 1'b0;
   int hold_asks = 0;

   initial begin
      for (int i = 0; i < THREADS; i++) begin
         waits_on_valid[i] = 1'b0;
         waits_on[i] = '0;
         points_to_valid[i] = 1'b0;
         points_to[i] = '0;
         marked[i] = 1'b0;
      end
      for (int i = 0; i < MUTEXES; i++) begin
         owner_valid[i] = 1'b0;
         owner[i] = '0;
      end
   end

   task automatic report_mismatch(input string what);
      $display("%0t mismatch: %s", $realtime, what);
      error_count++;
   endtask

   task automatic expect_result(input logic deadlock, input logic [TW-1:0] member,
                                input logic last);
      cycle_entry_type entry;
      entry.deadlock = deadlock;
      entry.member = member;
      entry.last = last;
      pending_reports = {pending_reports, entry};
   endtask

   function automatic int vertex_count();
      if (active_cfg == '0) return 1;
      if (int'(active_cfg) > THREADS) return THREADS;
      return int'(active_cfg);
   endfunction

   function automatic bit next_thread(input int v, output logic [TW-1:0] nx);
      nx = '0;
      if (v >= THREADS || !points_to_valid[v]) return 1'b0;
      nx = points_to[v];
      return 1'b1;
   endfunction

   // walk the ring from the meeting vertex; capped at the active count
   task automatic list_ring(input int start);
      logic [TW-1:0] ring[THREADS];
      logic [TW-1:0] nx;
      int n, count, cur;
      bit more;
      n = vertex_count();
      cur = start;
      count = 0;
      do begin
         ring[count] = TW'(cur);
         count++;
         more = next_thread(cur, nx);
         cur = int'(nx);
      end while (more && cur != start && count < n);
      for (int k = 0; k < count; k++)
         expect_result(1'b1, ring[k], (k == count - 1));
   endtask

   task automatic search_wait_cycles();
      logic [TW-1:0] f1, f2, s1;
      int n, slow, fast, steps;
      bit found;
      n = vertex_count();
      found = 1'b0;
      for (int i = 0; i < THREADS; i++) marked[i] = 1'b0;
      for (int i = 0; i < n && !found; i++) begin
         if (marked[i]) continue;
         slow = i;
         fast = i;
         steps = 0;
         while (steps < STEP_LIMIT && !found) begin
            if (!next_thread(fast, f1)) break;
            if (!next_thread(int'(f1), f2)) break;
            marked[slow] = 1'b1;
            marked[fast] = 1'b1;
            if (!next_thread(slow, s1)) break;
            slow = int'(s1);
            fast = int'(f2);
            steps++;
            if (slow == fast) begin
               list_ring(slow);
               found = 1'b1;
            end
         end
      end
      if (!found)
         expect_result(1'b0, '0, 1'b1);
   endtask

   task automatic predict_event(input logic [OP_W-1:0] op, input logic [TW-1:0] th,
                                input logic [MW-1:0] mx);
      int n;
      n = vertex_count();
      if (op == mdd_pkg::OP_NEED) begin
         waits_on_valid[th] = 1'b1;
         waits_on[th] = mx;
         points_to_valid[th] = owner_valid[mx];
         points_to[th] = owner[mx];
         search_wait_cycles();
      end else if (op == mdd_pkg::OP_HAVE) begin
         owner_valid[mx] = 1'b1;
         owner[mx] = th;
         waits_on_valid[th] = 1'b0;
         waits_on[th] = '0;
         points_to_valid[th] = 1'b0;
         points_to[th] = '0;
         // only waiters below the active count are re-pointed
         for (int i = 0; i < n; i++) begin
            if (waits_on_valid[i] && waits_on[i] == mx) begin
               points_to_valid[i] = 1'b1;
               points_to[i] = th;
            end
         end
      end else if (op == mdd_pkg::OP_FREE) begin
         owner_valid[mx] = 1'b0;
         owner[mx] = '0;
         for (int i = 0; i < n; i++) begin
            if (waits_on_valid[i] && waits_on[i] == mx) begin
               points_to_valid[i] = 1'b0;
               points_to[i] = '0;
            end
         end
      end
   endtask

   task automatic send_event(input logic [OP_W-1:0] op, input logic [TW-1:0] th,
                             input logic [MW-1:0] mx);
      if (!sender_calm && $urandom_range(0, 99) < 35) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat ($urandom_range(0, 3)) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= REQ_DATA_W'({mx, th});
      do @(posedge clock); while (!req_tready);
      predict_event(op, th, mx);
      sent_count++;
   endtask

   task automatic park_sender();
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   task automatic await_results();
      int waited;
      waited = 0;
      while (pending_reports.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (pending_reports.size() != 0) begin
         report_mismatch($sformatf("%0d expected results never arrived",
                                   pending_reports.size()));
         pending_reports.delete();
      end
      // have/free events give no result; let the last one finish
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_active(input logic [CFG_W-1:0] value);
      park_sender();
      await_results();
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      active_cfg = value;
   endtask

   // a have by each waiting thread on a spare lock clears every wait, then the lock is freed again
   task automatic release_all_waits();
      bit waiting[THREADS];
      bit any;
      any = 1'b0;
      for (int t = 0; t < THREADS; t++) begin
         waiting[t] = waits_on_valid[t];
         any |= waiting[t];
      end
      for (int t = 0; t < THREADS; t++)
         if (waiting[t]) send_event(mdd_pkg::OP_HAVE, TW'(t), SPARE_LOCK);
      if (any) send_event(mdd_pkg::OP_FREE, '0, SPARE_LOCK);
   endtask

   task automatic send_noise_event();
      logic [MW-1:0] mx;
      mx = ($urandom_range(0, 1) != 0) ? MW'($urandom_range(0, 7)) : MW'($urandom_range(0, 63));
      send_event(OP_W'($urandom_range(0, 3)), TW'($urandom_range(0, THREADS - 1)), mx);
   endtask

   // k threads each hold one lock and need the next one; flawed rings break it
   task automatic run_wait_ring(input int k, input bit flawed);
      int order[THREADS];
      logic [MW-1:0] locks[THREADS];
      logic [MW-1:0] mx;
      int base, j, tmp, flaw;
      for (int i = 0; i < THREADS; i++) order[i] = i;
      for (int i = THREADS - 1; i > 0; i--) begin
         j = $urandom_range(0, i);
         tmp = order[i];
         order[i] = order[j];
         order[j] = tmp;
      end
      base = $urandom_range(0, MUTEXES - 1);
      for (int i = 0; i < k; i++) locks[i] = MW'(base + 7 * i);
      flaw = flawed ? $urandom_range(0, 2) : 3;
      for (int i = 0; i < k; i++)
         if (!(flaw == 0 && i == k - 1)) send_event(mdd_pkg::OP_HAVE, TW'(order[i]), locks[i]);
      for (int i = 0; i < k; i++) begin
         if (flaw == 1 && i == k - 1)
            send_event(mdd_pkg::OP_FREE, TW'(order[$urandom_range(0, k - 1)]), locks[0]);
         mx = (flaw == 2 && i == k - 1) ? MW'($urandom_range(0, 63)) : locks[(i + 1) % k];
         send_event(mdd_pkg::OP_NEED, TW'(order[i]), mx);
      end
   endtask

   task automatic test_empty_graph();
      send_event(mdd_pkg::OP_NEED, 4'd0, 6'd0);
   endtask

   task automatic test_pair_deadlock();
      send_event(mdd_pkg::OP_HAVE, 4'd0, 6'd1);
      send_event(mdd_pkg::OP_HAVE, 4'd1, 6'd2);
      send_event(mdd_pkg::OP_NEED, 4'd0, 6'd2);
      send_event(mdd_pkg::OP_NEED, 4'd1, 6'd1);
      release_all_waits();
   endtask

   task automatic test_field_extremes();
      send_event(mdd_pkg::OP_HAVE, 4'd15, 6'd63);
      send_event(mdd_pkg::OP_NEED, 4'd14, 6'd63);
      send_event(OP_UNUSED, 4'd14, 6'd63);            // ignored
      send_event(mdd_pkg::OP_FREE, 4'd3, 6'd63);      // freed by a thread that does not hold it
      send_event(mdd_pkg::OP_NEED, 4'd15, 6'd42);
      release_all_waits();
   endtask

   task automatic test_active_clamp();
      // three-thread ring listed through only two vertices
      write_active(5'd2);
      for (int i = 0; i < 3; i++) send_event(mdd_pkg::OP_HAVE, TW'(i), MW'(10 + i));
      for (int i = 0; i < 3; i++)
         send_event(mdd_pkg::OP_NEED, TW'(i), MW'(10 + (i + 1) % 3));
      release_all_waits();
      // zero clamps to one; a thread needing its own lock waits on itself
      write_active(5'd0);
      send_event(mdd_pkg::OP_HAVE, 4'd0, 6'd5);
      send_event(mdd_pkg::OP_NEED, 4'd0, 6'd5);
      release_all_waits();
      write_active(5'd31);
      send_event(mdd_pkg::OP_NEED, 4'd2, 6'd9);
   endtask

   task automatic test_random_traffic();
      logic [CFG_W-1:0] settings[7];
      int phase_start, r;
      settings[0] = 5'd16;
      settings[1] = 5'd1;
      settings[2] = CFG_W'($urandom_range(1, 31));
      settings[3] = 5'd0;
      settings[4] = 5'd17;
      settings[5] = CFG_W'($urandom_range(2, 15));
      settings[6] = 5'd31;
      for (int p = 0; p < 7; p++) begin
         write_active(settings[p]);
         sender_calm = (p == 2);
         receiver_calm = (p == 2);
         phase_start = sent_count;
         while (sent_count - phase_start < 8) begin
            r = $urandom_range(0, 99);
            if (r < 60)
               run_wait_ring(($urandom_range(0, 9) == 0) ? $urandom_range(6, THREADS)
                                                         : $urandom_range(2, 5), 1'b0);
            else if (r < 75)
               run_wait_ring($urandom_range(2, 5), 1'b1);
            else
               repeat ($urandom_range(1, 3)) send_noise_event();
            if ($urandom_range(0, 1) != 0) release_all_waits();
         end
      end
      sender_calm = 1'b0;
      receiver_calm = 1'b0;
   endtask

   task automatic test_backpressure();
      write_active(5'd16);
      hold_asks++;
      run_wait_ring(4, 1'b0);
      repeat (4) send_event(mdd_pkg::OP_NEED, TW'($urandom_range(0, THREADS - 1)),
                            MW'($urandom_range(0, 63)));
      park_sender();
      await_results();
      release_all_waits();
   endtask

   // receiver: random stalls, calm stretches and one long hold-off
   int hold_seen = 0;
   int hold_left = 0;
   always @(negedge clock) begin
      if (hold_seen != hold_asks) begin
         hold_seen = hold_asks;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else if (receiver_calm) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= 35);
      end
   end

   always @(posedge clock) begin : check_results
      cycle_entry_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_reports.size() == 0) begin
            report_mismatch($sformatf("unexpected result data %h last %b", rsp_tdata, rsp_tlast));
         end else begin
            want = pending_reports.pop_front();
            if (rsp_tdata[0] !== want.deadlock)
               report_mismatch($sformatf("deadlock got %b want %b", rsp_tdata[0], want.deadlock));
            if (rsp_tdata[TW:1] !== want.member)
               report_mismatch($sformatf("member got %0d want %0d", rsp_tdata[TW:1], want.member));
            if (rsp_tlast !== want.last)
               report_mismatch($sformatf("last got %b want %b", rsp_tlast, want.last));
         end
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_empty_graph();
      test_pair_deadlock();
      test_field_extremes();
      test_active_clamp();
      test_backpressure();
      test_random_traffic();
      park_sender();
      await_results();
      if (error_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   initial begin
      #15_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule

FILE: sim.f
+incdir+src
src/mdd_pkg.sv
src/mdd_ram.sv
src/mdd_graph.sv
src/mdd_walker.sv
src/mutex_deadlock_detector_unit.sv
tb/tb_top.sv
